>>> rtl/core/otoc_pkg.sv
// ----------------------------------------------------------------------------
// otoc_pkg
// shared types and constants of the over-temperature / over-current monitor
// ----------------------------------------------------------------------------
package otoc_pkg;

    localparam int SMP_W   = 10;                 // adc sample width
    localparam int THR_W   = 10;                 // threshold register width
    localparam int STEP_W  = 8;                  // pattern step counters
    localparam int FAN_W   = 8;
    localparam int BURST_W = 2;
    localparam int ADDR_W  = 5;                  // 8 registers at 4-byte spacing
    localparam int DATA_W  = 32;

    localparam logic [THR_W-1:0]  RST_CURRENT_THR  = THR_W'(100);
    localparam logic [THR_W-1:0]  RST_TEMP_THR     = THR_W'(600);
    localparam logic [THR_W-1:0]  RST_SHUTDOWN_THR = THR_W'(560);
    localparam logic [THR_W-1:0]  RST_PWM_OFFSET   = THR_W'(550);
    localparam logic [STEP_W-1:0] RST_BEEP_ON      = STEP_W'(2);
    localparam logic [STEP_W-1:0] RST_BEEP_OFF     = STEP_W'(6);
    localparam logic [STEP_W-1:0] RST_BEEP_OFF_LNG = STEP_W'(24);
    localparam logic [STEP_W-1:0] RST_TICK_DIV     = STEP_W'(6);
    localparam logic [BURST_W-1:0] BURST_MAX       = '1;

    typedef enum logic [1:0] {
        ACT_CURRENT = 2'd0,
        ACT_TEMP    = 2'd1,
        ACT_TICK    = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        REG_CURRENT_THR  = 3'd0,
        REG_TEMP_THR     = 3'd1,
        REG_SHUTDOWN_THR = 3'd2,
        REG_PWM_OFFSET   = 3'd3,
        REG_BEEP_ON      = 3'd4,
        REG_BEEP_OFF     = 3'd5,
        REG_BEEP_OFF_LNG = 3'd6,
        REG_TICK_DIV     = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [THR_W-1:0]  current_thr;
        logic [THR_W-1:0]  temp_thr;
        logic [THR_W-1:0]  shutdown_thr;
        logic [THR_W-1:0]  pwm_offset;
        logic [STEP_W-1:0] beep_on;
        logic [STEP_W-1:0] beep_off;
        logic [STEP_W-1:0] beep_off_long;
        logic [STEP_W-1:0] tick_div;
    } t_cfg;

    typedef struct packed {
        logic off;
        logic blink;
        logic beep;
        logic curr;
        logic heat;
    } t_flags;

    // packed so that beep_gate lands in bit 0
    typedef struct packed {
        logic             measure_request;
        logic [FAN_W-1:0] fan_pwm;
        logic             tone_select;
        logic             current_alarm;
        logic             heat_alarm;
        logic             output_disable;
        logic             blink_led;
        logic             beep_gate;
    } t_result;

    localparam int RES_W = $bits(t_result);

endpackage

>>> rtl/core/overtemp_overcurrent_alarm.sv
// ----------------------------------------------------------------------------
// overtemp_overcurrent_alarm
// power-supply alarm monitor for current, temperature and tick beats
//
// Each input beat (current sample, temperature sample or base tick, chosen
// by tuser) yields exactly one result beat carrying the alarm flags, beep
// and lamp state, tone pitch, fan compare value and the measure request.
// A beat is registered on entry, evaluated in a single pass of logic and
// held in an output register, so the block takes one beat per clock. Master
// valid rises once the beat has passed the input register and then the
// result register. The block stalls only when the output register is full
// and not being drained. Temperature values fall as heat rises: an alarm is
// raised below its threshold and cleared above threshold plus one. The
// stored temperature comes out of reset at full scale so nothing alarms
// before the first reading. Config registers sit on the apb port at byte
// offsets 0x00..0x1c and are meant to be written while no beat is in
// flight.
// ----------------------------------------------------------------------------
module overtemp_overcurrent_alarm (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // slave side
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [15:0]                 i_s_axis_tdata,   // [9:0] sample
    input  logic [1:0]                  i_s_axis_tuser,   // [1:0] action
    // master side
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // [0] beep_gate [1] blink_led [2] output_disable [3] heat_alarm
    // [4] current_alarm [5] tone_select [13:6] fan_pwm [14] measure_request
    output logic [15:0]                 o_m_axis_tdata,
    // config port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [otoc_pkg::ADDR_W-1:0] paddr,
    input  logic [otoc_pkg::DATA_W-1:0] pwdata,
    output logic [otoc_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    otoc_pkg::t_cfg              w_cfg;
    otoc_pkg::t_result           w_res;

    // input register
    logic                        r_in_valid;
    otoc_pkg::t_action           r_in_action;
    logic [otoc_pkg::SMP_W-1:0]  r_in_sample;

    // result register
    logic                        r_out_valid;
    otoc_pkg::t_result           r_out;

    logic                        w_advance;
    logic                        w_in_acc;

    // the held beat moves on when the result register is free or draining
    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    otoc_cfg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    otoc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_action (r_in_action),
        .i_sample (r_in_sample),
        .i_cfg    (w_cfg),
        .o_res    (w_res)
    );

    // input stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    // input stage payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_action <= otoc_pkg::t_action'(i_s_axis_tuser);
            r_in_sample <= i_s_axis_tdata[otoc_pkg::SMP_W-1:0];
        end
    end

    // result stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(16 - otoc_pkg::RES_W){1'b0}}, r_out};

    // a beat taken into evaluation always shows up on the master side
    a_advance_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> o_m_axis_tvalid)
        else $error("evaluated beat produced no result");

    // a result the sink has not taken blocks evaluation of the held beat
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |-> !w_advance)
        else $error("pending result overwritten");

    // a held beat that could not advance stays in the input register
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_sample)))
        else $error("stalled input beat lost");

endmodule

>>> rtl/core/otoc_cfg_regs.sv
// ----------------------------------------------------------------------------
// otoc_cfg_regs
// apb register bank holding thresholds and beep pattern timing
// ----------------------------------------------------------------------------
module otoc_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [otoc_pkg::ADDR_W-1:0]   paddr,
    input  logic [otoc_pkg::DATA_W-1:0]   pwdata,
    output logic [otoc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output otoc_pkg::t_cfg                o_cfg
);

    otoc_pkg::t_cfg   r_cfg;
    otoc_pkg::t_cfg   n_cfg;
    otoc_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = otoc_pkg::t_reg_idx'(paddr[otoc_pkg::ADDR_W-1:2]);

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                otoc_pkg::REG_CURRENT_THR:
                    n_cfg.current_thr   = pwdata[otoc_pkg::THR_W-1:0];
                otoc_pkg::REG_TEMP_THR:
                    n_cfg.temp_thr      = pwdata[otoc_pkg::THR_W-1:0];
                otoc_pkg::REG_SHUTDOWN_THR:
                    n_cfg.shutdown_thr  = pwdata[otoc_pkg::THR_W-1:0];
                otoc_pkg::REG_PWM_OFFSET:
                    n_cfg.pwm_offset    = pwdata[otoc_pkg::THR_W-1:0];
                otoc_pkg::REG_BEEP_ON:
                    n_cfg.beep_on       = pwdata[otoc_pkg::STEP_W-1:0];
                otoc_pkg::REG_BEEP_OFF:
                    n_cfg.beep_off      = pwdata[otoc_pkg::STEP_W-1:0];
                otoc_pkg::REG_BEEP_OFF_LNG:
                    n_cfg.beep_off_long = pwdata[otoc_pkg::STEP_W-1:0];
                otoc_pkg::REG_TICK_DIV:
                    n_cfg.tick_div      = pwdata[otoc_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.current_thr   <= otoc_pkg::RST_CURRENT_THR;
            r_cfg.temp_thr      <= otoc_pkg::RST_TEMP_THR;
            r_cfg.shutdown_thr  <= otoc_pkg::RST_SHUTDOWN_THR;
            r_cfg.pwm_offset    <= otoc_pkg::RST_PWM_OFFSET;
            r_cfg.beep_on       <= otoc_pkg::RST_BEEP_ON;
            r_cfg.beep_off      <= otoc_pkg::RST_BEEP_OFF;
            r_cfg.beep_off_long <= otoc_pkg::RST_BEEP_OFF_LNG;
            r_cfg.tick_div      <= otoc_pkg::RST_TICK_DIV;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        prdata = '0;
        case (w_idx)
            otoc_pkg::REG_CURRENT_THR:
                prdata = otoc_pkg::DATA_W'(r_cfg.current_thr);
            otoc_pkg::REG_TEMP_THR:
                prdata = otoc_pkg::DATA_W'(r_cfg.temp_thr);
            otoc_pkg::REG_SHUTDOWN_THR:
                prdata = otoc_pkg::DATA_W'(r_cfg.shutdown_thr);
            otoc_pkg::REG_PWM_OFFSET:
                prdata = otoc_pkg::DATA_W'(r_cfg.pwm_offset);
            otoc_pkg::REG_BEEP_ON:
                prdata = otoc_pkg::DATA_W'(r_cfg.beep_on);
            otoc_pkg::REG_BEEP_OFF:
                prdata = otoc_pkg::DATA_W'(r_cfg.beep_off);
            otoc_pkg::REG_BEEP_OFF_LNG:
                prdata = otoc_pkg::DATA_W'(r_cfg.beep_off_long);
            otoc_pkg::REG_TICK_DIV:
                prdata = otoc_pkg::DATA_W'(r_cfg.tick_div);
            default: prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/core/otoc_core.sv
// ----------------------------------------------------------------------------
// otoc_core
// alarm state, hysteresis checks, tick divider and beep/blink pattern
// ----------------------------------------------------------------------------
module otoc_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  otoc_pkg::t_action            i_action,
    input  logic [otoc_pkg::SMP_W-1:0]   i_sample,
    input  otoc_pkg::t_cfg               i_cfg,
    output otoc_pkg::t_result            o_res
);

    logic [otoc_pkg::STEP_W-1:0]  r_tick_div,  n_tick_div;
    logic [otoc_pkg::STEP_W-1:0]  r_pat_cnt,   n_pat_cnt;
    logic [otoc_pkg::BURST_W-1:0] r_burst,     n_burst;
    logic [otoc_pkg::STEP_W-1:0]  r_off_steps, n_off_steps;
    otoc_pkg::t_flags             r_flags,     n_flags;
    logic                         r_tone,      n_tone;
    logic [otoc_pkg::SMP_W-1:0]   r_temp,      n_temp;
    logic [otoc_pkg::FAN_W-1:0]   r_fan,       n_fan;
    logic                         w_req;

    always_comb begin
        n_tick_div  = r_tick_div;
        n_pat_cnt   = r_pat_cnt;
        n_burst     = r_burst;
        n_off_steps = r_off_steps;
        n_flags     = r_flags;
        n_tone      = r_tone;
        n_temp      = r_temp;
        n_fan       = r_fan;
        w_req       = 1'b0;

        // current check runs first, so heat pitch wins when both hold
        if (i_action == otoc_pkg::ACT_CURRENT) begin
            if (i_sample < otoc_pkg::SMP_W'(i_cfg.current_thr)) begin
                n_tone = 1'b1;
                if (!n_flags.curr) begin
                    n_flags.curr = 1'b1;
                    n_pat_cnt    = i_cfg.beep_off - 1'b1;
                    n_burst      = '0;
                    n_off_steps  = i_cfg.beep_off;
                end
            end else if ({1'b0, i_sample} > ({1'b0, i_cfg.current_thr} + 1'b1)) begin
                if (n_flags.curr) begin
                    n_flags.curr = 1'b0;
                    n_flags.beep = 1'b0;
                    n_burst      = '0;
                    n_off_steps  = i_cfg.beep_off;
                end
            end
        end

        if (i_action == otoc_pkg::ACT_TEMP) begin
            n_temp = i_sample;
            n_fan  = i_sample[otoc_pkg::FAN_W-1:0] - i_cfg.pwm_offset[otoc_pkg::FAN_W-1:0];
        end

        // heat check on every defined action
        if (i_action != otoc_pkg::ACT_NONE) begin
            if (n_temp < otoc_pkg::SMP_W'(i_cfg.temp_thr)) begin
                n_tone = 1'b0;
                if (!n_flags.heat) begin
                    n_flags.heat = 1'b1;
                    n_pat_cnt    = i_cfg.beep_off - 1'b1;
                    n_burst      = '0;
                    n_off_steps  = i_cfg.beep_off;
                end
                if (n_temp < otoc_pkg::SMP_W'(i_cfg.shutdown_thr)) begin
                    n_flags.off = 1'b1;
                end
            end else if ({1'b0, n_temp} > ({1'b0, i_cfg.temp_thr} + 1'b1)) begin
                if (n_flags.heat) begin
                    n_flags.heat = 1'b0;
                    n_flags.off  = 1'b0;
                    n_flags.beep = 1'b0;
                    n_burst      = '0;
                    n_off_steps  = i_cfg.beep_off;
                end
            end
        end

        if (i_action == otoc_pkg::ACT_TICK) begin
            n_tick_div = r_tick_div + 1'b1;
            // a divide setting of zero acts as one
            if (n_tick_div >= i_cfg.tick_div) begin
                n_tick_div = '0;
                w_req      = 1'b1;
                if (n_flags.heat || n_flags.curr) begin
                    if (n_burst == otoc_pkg::BURST_MAX) begin
                        n_off_steps = i_cfg.beep_off_long;
                    end
                    if (n_pat_cnt == n_off_steps) begin
                        n_flags.blink = 1'b1;
                        n_flags.beep  = 1'b1;
                        n_pat_cnt     = '0;
                        if (n_burst != otoc_pkg::BURST_MAX) begin
                            n_burst = n_burst + 1'b1;
                        end
                    end
                    if (n_pat_cnt == i_cfg.beep_on) begin
                        n_flags.blink = 1'b0;
                        n_flags.beep  = 1'b0;
                    end
                end else if (n_pat_cnt == i_cfg.beep_on) begin
                    n_flags.beep = 1'b0;
                    n_off_steps  = i_cfg.beep_off;
                end
                n_pat_cnt = n_pat_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_div  <= '0;
            r_pat_cnt   <= '0;
            r_burst     <= '0;
            r_off_steps <= otoc_pkg::RST_BEEP_OFF;
            r_flags     <= '0;
            r_tone      <= 1'b0;
            r_temp      <= '1;
            r_fan       <= '0;
        end else if (i_step) begin
            r_tick_div  <= n_tick_div;
            r_pat_cnt   <= n_pat_cnt;
            r_burst     <= n_burst;
            r_off_steps <= n_off_steps;
            r_flags     <= n_flags;
            r_tone      <= n_tone;
            r_temp      <= n_temp;
            r_fan       <= n_fan;
        end
    end

    always_comb begin
        o_res.measure_request = w_req;
        o_res.fan_pwm         = n_fan;
        o_res.tone_select     = n_tone;
        o_res.current_alarm   = n_flags.curr;
        o_res.heat_alarm      = n_flags.heat;
        o_res.output_disable  = n_flags.off;
        o_res.blink_led       = n_flags.blink;
        o_res.beep_gate       = n_flags.beep;
    end

    // output shutdown only latches under a heat alarm
    a_off_needs_heat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flags.off |-> r_flags.heat)
        else $error("output disable without heat alarm");

    // the beep never sounds once both alarms are gone
    a_beep_needs_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flags.beep |-> (r_flags.heat || r_flags.curr))
        else $error("beep active with no alarm");

    // a temperature beat lands in the stored temperature
    a_temp_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_action == otoc_pkg::ACT_TEMP) |=> r_temp == $past(i_sample))
        else $error("temperature sample not stored");

endmodule

>>> tb/otoc_status_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otoc_status_checker
// watches the monitor's stream and config ports and checks every status beat
//
// Keeps its own copy of the alarm, pattern and fan state, updated on every
// accepted input beat. The predicted status is queued and compared field by
// field with each accepted output beat. Register writes are shadowed and
// register reads are checked against the shadow.
// ----------------------------------------------------------------------------
module otoc_status_checker
    import otoc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_s_tready,
    input  logic [15:0]       i_s_tdata,     // [9:0] sample
    input  logic [1:0]        i_s_tuser,     // [1:0] action
    input  logic              i_m_tvalid,
    input  logic              i_m_tready,
    input  logic [15:0]       i_m_tdata,     // status, beep_gate in bit 0
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [DATA_W-1:0] i_pwdata,
    input  logic [DATA_W-1:0] i_prdata,
    input  logic              i_pready,
    output int                o_awaited_beats,
    output int                o_mismatch_count
);

    // register shadow
    t_cfg knobs;

    // monitor state
    logic [STEP_W-1:0]  tick_cnt;
    logic [STEP_W-1:0]  step_cnt;
    logic [STEP_W-1:0]  off_len;
    logic [BURST_W-1:0] bursts;
    t_flags             flags;
    logic               tone_curr;
    logic [SMP_W-1:0]   temp_now;
    logic [FAN_W-1:0]   fan_now;

    t_result awaited_status[$];
    int      status_beats;

    task automatic flag_mismatch(input string what, input int got, input int want);
        if (o_mismatch_count < 40)
            $display("mismatch on %s: got %0d want %0d (status beat %0d, t=%0t)",
                     what, got, want, status_beats, $realtime);
        o_mismatch_count++;
    endtask

    task automatic raise_alarm(input bit is_heat);
        if (is_heat)
            flags.heat = 1'b1;
        else
            flags.curr = 1'b1;
        step_cnt = knobs.beep_off - 8'd1;
        bursts   = '0;
        off_len  = knobs.beep_off;
    endtask

    task automatic drop_alarm(input bit is_heat);
        if (is_heat)
            flags.heat = 1'b0;
        else
            flags.curr = 1'b0;
        bursts     = '0;
        off_len    = knobs.beep_off;
        flags.beep = 1'b0;
    endtask

    task automatic judge_current(input logic [SMP_W-1:0] smp);
        if (smp < knobs.current_thr) begin
            tone_curr = 1'b1;
            if (!flags.curr)
                raise_alarm(1'b0);
        end else if (int'(smp) > int'(knobs.current_thr) + 1) begin
            if (flags.curr)
                drop_alarm(1'b0);
        end
    endtask

    task automatic judge_heat();
        if (temp_now < knobs.temp_thr) begin
            tone_curr = 1'b0;
            if (!flags.heat)
                raise_alarm(1'b1);
            if (temp_now < knobs.shutdown_thr)
                flags.off = 1'b1;
        end else if (int'(temp_now) > int'(knobs.temp_thr) + 1) begin
            if (flags.heat) begin
                flags.off = 1'b0;
                drop_alarm(1'b1);
            end
        end
    endtask

    // one beep/blink pattern step
    task automatic advance_pattern();
        if (flags.heat || flags.curr) begin
            if (bursts > 2'd2)
                off_len = knobs.beep_off_long;
            if (step_cnt == off_len) begin
                flags.blink = 1'b1;
                flags.beep  = 1'b1;
                step_cnt    = '0;
                if (bursts < 2'd3)
                    bursts++;
            end
            if (step_cnt == knobs.beep_on) begin
                flags.blink = 1'b0;
                flags.beep  = 1'b0;
            end
        end else if (step_cnt == knobs.beep_on) begin
            flags.beep = 1'b0;
            off_len    = knobs.beep_off;
        end
        step_cnt = step_cnt + 8'd1;
    endtask

    task automatic predict_status(input t_action act, input logic [SMP_W-1:0] smp,
                                  output t_result res);
        logic req;
        req = 1'b0;
        case (act)
            ACT_CURRENT: begin
                judge_current(smp);
                judge_heat();
            end
            ACT_TEMP: begin
                temp_now = smp;
                fan_now  = FAN_W'(smp - knobs.pwm_offset);
                judge_heat();
            end
            ACT_TICK: begin
                judge_heat();
                tick_cnt = tick_cnt + 8'd1;
                if (tick_cnt >= knobs.tick_div) begin
                    tick_cnt = '0;
                    advance_pattern();
                    req = 1'b1;
                end
            end
            default: ;
        endcase
        res.beep_gate       = flags.beep;
        res.blink_led       = flags.blink;
        res.output_disable  = flags.off;
        res.heat_alarm      = flags.heat;
        res.current_alarm   = flags.curr;
        res.tone_select     = tone_curr;
        res.fan_pwm         = fan_now;
        res.measure_request = req;
    endtask

    always @(posedge i_clk) begin : watch
        t_result   seen;
        t_result   want;
        t_reg_idx  idx;
        logic [DATA_W-1:0] rd_want;
        if (!i_rst_n) begin
            knobs            = '{RST_CURRENT_THR, RST_TEMP_THR, RST_SHUTDOWN_THR,
                                 RST_PWM_OFFSET, RST_BEEP_ON, RST_BEEP_OFF,
                                 RST_BEEP_OFF_LNG, RST_TICK_DIV};
            tick_cnt         = '0;
            step_cnt         = '0;
            bursts           = '0;
            off_len          = RST_BEEP_OFF;
            flags            = '0;
            tone_curr        = 1'b0;
            temp_now         = '1;          // full scale: cold
            fan_now          = '0;
            status_beats     = 0;
            o_mismatch_count = 0;
            awaited_status.delete();
        end else begin
            idx = t_reg_idx'(i_paddr[ADDR_W-1:2]);

            // register write lands on the access edge
            if (i_psel && i_penable && i_pready && i_pwrite) begin
                case (idx)
                    REG_CURRENT_THR:  knobs.current_thr   = i_pwdata[THR_W-1:0];
                    REG_TEMP_THR:     knobs.temp_thr      = i_pwdata[THR_W-1:0];
                    REG_SHUTDOWN_THR: knobs.shutdown_thr  = i_pwdata[THR_W-1:0];
                    REG_PWM_OFFSET:   knobs.pwm_offset    = i_pwdata[THR_W-1:0];
                    REG_BEEP_ON:      knobs.beep_on       = i_pwdata[STEP_W-1:0];
                    REG_BEEP_OFF:     knobs.beep_off      = i_pwdata[STEP_W-1:0];
                    REG_BEEP_OFF_LNG: knobs.beep_off_long = i_pwdata[STEP_W-1:0];
                    default:          knobs.tick_div      = i_pwdata[STEP_W-1:0];
                endcase
            end

            if (i_psel && i_penable && i_pready && !i_pwrite) begin
                case (idx)
                    REG_CURRENT_THR:  rd_want = DATA_W'(knobs.current_thr);
                    REG_TEMP_THR:     rd_want = DATA_W'(knobs.temp_thr);
                    REG_SHUTDOWN_THR: rd_want = DATA_W'(knobs.shutdown_thr);
                    REG_PWM_OFFSET:   rd_want = DATA_W'(knobs.pwm_offset);
                    REG_BEEP_ON:      rd_want = DATA_W'(knobs.beep_on);
                    REG_BEEP_OFF:     rd_want = DATA_W'(knobs.beep_off);
                    REG_BEEP_OFF_LNG: rd_want = DATA_W'(knobs.beep_off_long);
                    default:          rd_want = DATA_W'(knobs.tick_div);
                endcase
                if (i_prdata !== rd_want)
                    flag_mismatch($sformatf("register %s read", idx.name()),
                                  int'(i_prdata), int'(rd_want));
            end

            // input side first, so a same-edge output beat sees an older entry
            if (i_s_tvalid && i_s_tready) begin
                predict_status(t_action'(i_s_tuser), i_s_tdata[SMP_W-1:0], want);
                awaited_status.push_back(want);
            end

            if (i_m_tvalid && i_m_tready) begin
                seen = t_result'(i_m_tdata[RES_W-1:0]);
                if (awaited_status.size() == 0) begin
                    flag_mismatch("unexpected status beat", int'(seen), 0);
                end else begin
                    want = awaited_status.pop_front();
                    if (seen.beep_gate !== want.beep_gate)
                        flag_mismatch("beep_gate", seen.beep_gate, want.beep_gate);
                    if (seen.blink_led !== want.blink_led)
                        flag_mismatch("blink_led", seen.blink_led, want.blink_led);
                    if (seen.output_disable !== want.output_disable)
                        flag_mismatch("output_disable", seen.output_disable,
                                      want.output_disable);
                    if (seen.heat_alarm !== want.heat_alarm)
                        flag_mismatch("heat_alarm", seen.heat_alarm, want.heat_alarm);
                    if (seen.current_alarm !== want.current_alarm)
                        flag_mismatch("current_alarm", seen.current_alarm,
                                      want.current_alarm);
                    if (seen.tone_select !== want.tone_select)
                        flag_mismatch("tone_select", seen.tone_select, want.tone_select);
                    if (seen.fan_pwm !== want.fan_pwm)
                        flag_mismatch("fan_pwm", seen.fan_pwm, want.fan_pwm);
                    if (seen.measure_request !== want.measure_request)
                        flag_mismatch("measure_request", seen.measure_request,
                                      want.measure_request);
                end
                status_beats++;
            end
        end
        o_awaited_beats = awaited_status.size();
    end

endmodule

>>> tb/tb_overtemp_overcurrent_alarm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_overtemp_overcurrent_alarm
// regression bench for the over-temperature / over-current alarm monitor
//
// Drives current samples, temperature samples, base ticks and the unused
// action through the slave stream, under several register settings from all
// zeros to all ones. A directed opening walks the thresholds, hysteresis,
// shutdown latch and pitch priority; random beats then hover around the
// thresholds so alarms come and go and the beep pattern runs deep. Both
// stream sides idle at random and the status side holds off once for a long
// stretch. Checking is done by the status checker beside the block.
// ----------------------------------------------------------------------------
module tb_overtemp_overcurrent_alarm;

    import otoc_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [15:0]       s_tdata;    // [9:0] sample, rest zero
    logic [1:0]        s_tuser;    // [1:0] action
    logic              m_tvalid;
    logic              m_tready;
    logic [15:0]       m_tdata;    // [0] beep .. [13:6] fan_pwm [14] measure_request
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int awaited_beats;
    int mismatch_count;

    // stimulus shaping, not prediction
    t_cfg plan;
    bit   alarm_bias;       // keep samples on the alarming side of the threshold
    bit   steady_send;      // stretch with no sender idling
    bit   stall_out_go;     // ask the status side for its long hold-off
    bit   stall_out_done;

    overtemp_overcurrent_alarm i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    otoc_status_checker i_status_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_s_tvalid       (s_tvalid),
        .i_s_tready       (s_tready),
        .i_s_tdata        (s_tdata),
        .i_s_tuser        (s_tuser),
        .i_m_tvalid       (m_tvalid),
        .i_m_tready       (m_tready),
        .i_m_tdata        (m_tdata),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .i_prdata         (prdata),
        .i_pready         (pready),
        .o_awaited_beats  (awaited_beats),
        .o_mismatch_count (mismatch_count)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // mostly short sender gaps, a few long ones, none in a steady stretch
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_send || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [SMP_W-1:0] near_value(input int center, input int spread);
        int v;
        v = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return SMP_W'(v);
    endfunction

    // samples hug the threshold so hysteresis and entry/exit get hit often
    function automatic logic [SMP_W-1:0] pick_sample(input int thr, input int deep_thr);
        int u;
        u = $urandom_range(0, 9);
        if (u < 2)
            return SMP_W'($urandom_range(0, 1023));
        if (u < 5)
            return near_value((u == 4) ? deep_thr : thr, 3);
        if (alarm_bias)
            return (thr == 0) ? '0 : SMP_W'($urandom_range(0, thr - 1));
        return (thr >= 1022) ? '1 : SMP_W'($urandom_range(thr + 2, 1023));
    endfunction

    // called and returns at a falling edge
    task automatic send_beat(input t_action act, input logic [SMP_W-1:0] smp);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = act;
        s_tdata  = {6'b0, smp};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    task automatic apb_access(input bit wr, input t_reg_idx idx, input logic [DATA_W-1:0] v);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {idx, 2'b00};
        pwdata  = v;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // drain the block before touching registers
    task automatic settle();
        s_tvalid = 1'b0;
        while (awaited_beats != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic load_knobs(input t_cfg c);
        plan = c;
        settle();
        apb_access(1'b1, REG_CURRENT_THR,  DATA_W'(c.current_thr));
        apb_access(1'b1, REG_TEMP_THR,     DATA_W'(c.temp_thr));
        apb_access(1'b1, REG_SHUTDOWN_THR, DATA_W'(c.shutdown_thr));
        apb_access(1'b1, REG_PWM_OFFSET,   DATA_W'(c.pwm_offset));
        apb_access(1'b1, REG_BEEP_ON,      DATA_W'(c.beep_on));
        apb_access(1'b1, REG_BEEP_OFF,     DATA_W'(c.beep_off));
        apb_access(1'b1, REG_BEEP_OFF_LNG, DATA_W'(c.beep_off_long));
        apb_access(1'b1, REG_TICK_DIV,     DATA_W'(c.tick_div));
        for (int k = 0; k < 8; k++)
            apb_access(1'b0, t_reg_idx'(k), '0);
    endtask

    task automatic random_phase(input int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 39) == 0)
                alarm_bias = !alarm_bias;
            if ($urandom_range(0, 79) == 0)
                steady_send = !steady_send;
            if (r < 50)
                send_beat(ACT_TICK, SMP_W'($urandom_range(0, 1023)));
            else if (r < 75)
                send_beat(ACT_TEMP, pick_sample(plan.temp_thr, plan.shutdown_thr));
            else if (r < 95)
                send_beat(ACT_CURRENT, pick_sample(plan.current_thr, plan.current_thr));
            else
                send_beat(ACT_NONE, SMP_W'($urandom_range(0, 1023)));
        end
    endtask

    // status side: random stalls, stall-free stretches, one long hold-off
    initial begin
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if (stall_out_go && !stall_out_done) begin
                // sender keeps offering, so the block fills and backs up
                m_tready = 1'b0;
                repeat (300) @(negedge clk);
                stall_out_done = 1'b1;
            end else if ($urandom_range(0, 9) == 0) begin
                m_tready = 1'b1;
                repeat ($urandom_range(50, 150)) @(negedge clk);
            end else begin
                m_tready = 1'b1;
                repeat ($urandom_range(1, 8)) @(negedge clk);
                m_tready = 1'b0;
                if ($urandom_range(0, 99) < 88)
                    repeat ($urandom_range(1, 2)) @(negedge clk);
                else
                    repeat ($urandom_range(10, 40)) @(negedge clk);
            end
        end
    end

    initial begin
        #10ms;
        $display("overtemp_overcurrent_alarm regression: fail");
        $finish;
    end

    initial begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = ACT_CURRENT;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        alarm_bias     = 1'b0;
        steady_send    = 1'b0;
        stall_out_go   = 1'b0;
        stall_out_done = 1'b0;
        plan = '{RST_CURRENT_THR, RST_TEMP_THR, RST_SHUTDOWN_THR, RST_PWM_OFFSET,
                 RST_BEEP_ON, RST_BEEP_OFF, RST_BEEP_OFF_LNG, RST_TICK_DIV};
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset values read back
        for (int k = 0; k < 8; k++)
            apb_access(1'b0, t_reg_idx'(k), '0);

        // directed opening on reset settings
        send_beat(ACT_TICK,    10'd0);
        send_beat(ACT_NONE,    10'd1023);    // unused action, no change
        send_beat(ACT_TEMP,    10'd1023);    // fan value wraps
        send_beat(ACT_CURRENT, 10'd1023);
        send_beat(ACT_CURRENT, 10'd0);       // current alarm, current pitch
        send_beat(ACT_CURRENT, 10'd101);     // inside hysteresis: holds
        send_beat(ACT_CURRENT, 10'd100);     // at threshold: holds
        send_beat(ACT_CURRENT, 10'd102);     // clears
        send_beat(ACT_TEMP,    10'd599);     // heat alarm
        send_beat(ACT_TEMP,    10'd0);       // shutdown latch
        send_beat(ACT_TEMP,    10'd601);     // heat holds, latch holds
        send_beat(ACT_CURRENT, 10'd0);       // both alarms, heat in hysteresis: current pitch
        repeat (12) send_beat(ACT_TICK, SMP_W'($urandom_range(0, 1023)));
        send_beat(ACT_TEMP,    10'd602);     // heat clears, latch released
        send_beat(ACT_CURRENT, 10'd1023);

        // fast pattern, with the long status hold-off
        load_knobs('{10'd100, 10'd600, 10'd560, 10'd550, 8'd1, 8'd2, 8'd5, 8'd1});
        stall_out_go = 1'b1;
        random_phase(300);

        // all zeros: a divide of zero steps the pattern on every tick
        load_knobs('0);
        random_phase(200);

        // all ones
        load_knobs('1);
        random_phase(200);

        // random settings, kept fast enough for the pattern to run
        repeat (3) begin
            load_knobs('{THR_W'($urandom_range(0, 1023)), THR_W'($urandom_range(0, 1023)),
                         THR_W'($urandom_range(0, 1023)), THR_W'($urandom_range(0, 1023)),
                         STEP_W'($urandom_range(0, 10)), STEP_W'($urandom_range(0, 12)),
                         STEP_W'($urandom_range(0, 20)), STEP_W'($urandom_range(1, 4))});
            random_phase(250);
        end

        // back to reset values, written explicitly
        load_knobs('{RST_CURRENT_THR, RST_TEMP_THR, RST_SHUTDOWN_THR, RST_PWM_OFFSET,
                     RST_BEEP_ON, RST_BEEP_OFF, RST_BEEP_OFF_LNG, RST_TICK_DIV});
        random_phase(300);

        settle();
        repeat (8) @(negedge clk);
        if (mismatch_count == 0)
            $display("overtemp_overcurrent_alarm regression: pass");
        else
            $display("overtemp_overcurrent_alarm regression: fail");
        $finish;
    end

endmodule
